// ----- rtl/ttt_pkg.sv -----
// Shared types, constants and sizes for the tap tempo tracker.
package ttt_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W         = 32 + $clog2(HISTORY_DEPTH);
  localparam int TS_W          = 64;
  localparam int IV_W          = 32;
  localparam int BPM_W         = 24;
  localparam int REM_W         = SUM_W + 1;
  localparam int DIV_CNT_W     = $clog2(TS_W + 1);

  localparam int MS_DIG_W      = 16;
  localparam int MS_REM_W      = 10;
  localparam int MS_V_W        = MS_REM_W + MS_DIG_W;
  localparam int MS_SRC_W      = 48;
  localparam int MS_CHUNKS     = MS_SRC_W / MS_DIG_W;
  localparam int MS_CNT_W      = 2;
  localparam int MS_REC_W      = 27;
  localparam int MS_SHIFT      = 36;
  localparam int MS_PROD_W     = MS_V_W + MS_REC_W;

  localparam logic [MS_V_W-1:0]   US_PER_MS      = MS_V_W'(1000);
  localparam logic [MS_REC_W-1:0] MS_RECIP       = MS_REC_W'(68719477);
  localparam logic [31:0]         BPM_Q8_NUM     = 32'd15360000;
  localparam logic [BPM_W-1:0]    BPM_Q8_DEFAULT = BPM_W'(30720);

  typedef enum logic {
    OP_TAP    = 1'b0,
    OP_FORGET = 1'b1
  } ttt_op_t;

  typedef struct packed {
    logic            has_diff;
    logic [TS_W-1:0] diff;
  } ttt_req_t;

  typedef struct packed {
    logic             start;
    logic             short_mode;
    logic [TS_W-1:0]  dividend;
    logic [SUM_W-1:0] divisor;
  } ttt_div_cmd_t;

  typedef struct packed {
    logic            done;
    logic [TS_W-1:0] quotient;
  } ttt_div_res_t;

endpackage

// ----- rtl/ttt_if.sv -----
// Request and result channel interfaces of the tap tempo tracker.
interface ttt_in_if;
  import ttt_pkg::*;
  logic            valid;
  logic            ready;
  logic [0:0]      op;
  logic [TS_W-1:0] timestamp_us;
  modport source (output valid, output op, output timestamp_us, input ready);
  modport sink   (input valid, input op, input timestamp_us, output ready);
endinterface

interface ttt_out_if;
  import ttt_pkg::*;
  logic             valid;
  logic             ready;
  logic             interval_valid;
  logic [IV_W-1:0]  interval_ms;
  logic [IV_W-1:0]  last_interval_ms;
  logic [BPM_W-1:0] bpm_q8;
  modport source (output valid, output interval_valid, output interval_ms,
                  output last_interval_ms, output bpm_q8, input ready);
  modport sink   (input valid, input interval_valid, input interval_ms,
                  input last_interval_ms, input bpm_q8, output ready);
endinterface

// ----- rtl/ttt_queue.sv -----
// Two-entry request queue between the front and back parts.
module ttt_queue
  import ttt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ttt_req_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output ttt_req_t head
);

  ttt_req_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/ttt_front.sv -----
// Front part: accept requests, track the pending tap, classify into the queue.
module ttt_front
  import ttt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ttt_in_if.sink       in_req,
  input  logic         q_full,
  output logic         q_push,
  output ttt_req_t     q_data
);

  logic [TS_W-1:0] prev_tap_r, prev_tap_nxt;
  logic [TS_W:0]   diff_ext;
  logic            accept;

  assign in_req.ready = !q_full;
  assign accept       = in_req.valid && !q_full;
  assign diff_ext     = {1'b0, in_req.timestamp_us} - {1'b0, prev_tap_r};

  always_comb begin
    q_push        = accept;
    q_data.diff   = diff_ext[TS_W-1:0];
    q_data.has_diff = (in_req.op == OP_TAP) && (prev_tap_r != '0) && !diff_ext[TS_W]
                      && (diff_ext[TS_W-1:0] != '0);
    prev_tap_nxt  = prev_tap_r;
    if (accept) begin
      prev_tap_nxt = (in_req.op == OP_FORGET) ? '0 : in_req.timestamp_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_tap_r <= '0;
    end else begin
      prev_tap_r <= prev_tap_nxt;
    end
  end

endmodule

// ----- rtl/ttt_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module ttt_div
  import ttt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  ttt_div_cmd_t cmd,
  output ttt_div_res_t res
);

  logic [TS_W-1:0]      dvd_r, dvd_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [REM_W-1:0]     rem_sh;
  logic                 fits;

  assign rem_sh = {rem_r[REM_W-2:0], dvd_r[TS_W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      dsr_nxt  = cmd.divisor;
      if (cmd.short_mode) begin
        dvd_nxt = {cmd.dividend[TS_W/2-1:0], (TS_W/2)'(0)};
        cnt_nxt = DIV_CNT_W'(TS_W / 2);
      end else begin
        dvd_nxt = cmd.dividend;
        cnt_nxt = DIV_CNT_W'(TS_W);
      end
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
      dvd_nxt = {dvd_r[TS_W-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done     = done_r;
  assign res.quotient = dvd_r;

endmodule

// ----- rtl/ttt_back.sv -----
// Back part: interval division, window update, tempo division, result register.
module ttt_back
  import ttt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  ttt_req_t     q_head,
  output logic         q_pop,
  output ttt_div_cmd_t div_cmd,
  input  ttt_div_res_t div_res,
  ttt_out_if.source    out_res
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MSQ   = 7'b0000010,
    S_MSR   = 7'b0000100,
    S_MSCHK = 7'b0001000,
    S_PUSH  = 7'b0010000,
    S_LOAD  = 7'b0100000,
    S_BPM   = 7'b1000000
  } ttt_state_t;

  ttt_state_t       state_r, state_nxt;
  logic [IV_W-1:0]  win_mem [HISTORY_DEPTH];
  logic [IV_W-1:0]  win_rd_r;
  logic             win_we;
  logic [IDX_W-1:0] widx_r, widx_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [IV_W-1:0]  iv_r, iv_nxt;
  logic [IV_W-1:0]  last_r, last_nxt;
  logic [BPM_W-1:0] bpm_r, bpm_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ivv_r;
  logic [IV_W-1:0]  out_iv_r;
  logic [IV_W-1:0]  out_last_r;
  logic [BPM_W-1:0] out_bpm_r;
  logic             out_load, out_ivv;
  logic [IV_W-1:0]  out_iv;
  logic             full_win;
  logic             slot_free;
  logic [MS_SRC_W-1:0] ms_src_r, ms_src_nxt;
  logic                ms_big_r, ms_big_nxt;
  logic [MS_REM_W-1:0] ms_rem_r, ms_rem_nxt;
  logic [MS_SRC_W-1:0] ms_q_r, ms_q_nxt;
  logic [MS_DIG_W-1:0] ms_qd_r, ms_qd_nxt;
  logic [MS_CNT_W-1:0] ms_cnt_r, ms_cnt_nxt;
  logic [MS_V_W-1:0]   ms_v;
  logic [MS_V_W-1:0]   ms_rem_full;
  logic [MS_PROD_W-1:0] ms_prod;

  assign full_win  = (fill_r == FILL_W'(HISTORY_DEPTH));
  assign slot_free = !out_valid_r || out_res.ready;

  assign ms_v        = {ms_rem_r, ms_src_r[MS_SRC_W-1 -: MS_DIG_W]};
  assign ms_prod     = MS_PROD_W'(ms_v) * MS_PROD_W'(MS_RECIP);
  assign ms_rem_full = ms_v - MS_V_W'(ms_qd_r) * US_PER_MS;

  always_comb begin
    state_nxt          = state_r;
    q_pop              = 1'b0;
    div_cmd.start      = 1'b0;
    div_cmd.short_mode = 1'b0;
    div_cmd.dividend   = '0;
    div_cmd.divisor    = '0;
    win_we             = 1'b0;
    widx_nxt           = widx_r;
    fill_nxt           = fill_r;
    sum_nxt            = sum_r;
    iv_nxt             = iv_r;
    last_nxt           = last_r;
    bpm_nxt            = bpm_r;
    out_load           = 1'b0;
    out_ivv            = 1'b0;
    out_iv             = '0;
    ms_src_nxt         = ms_src_r;
    ms_big_nxt         = ms_big_r;
    ms_rem_nxt         = ms_rem_r;
    ms_q_nxt           = ms_q_r;
    ms_qd_nxt          = ms_qd_r;
    ms_cnt_nxt         = ms_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop = 1'b1;
          if (q_head.has_diff) begin
            ms_src_nxt = q_head.diff[MS_SRC_W-1:0];
            ms_big_nxt = (q_head.diff[TS_W-1:MS_SRC_W] != '0);
            ms_rem_nxt = '0;
            ms_q_nxt   = '0;
            ms_cnt_nxt = MS_CNT_W'(MS_CHUNKS);
            state_nxt  = S_MSQ;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      S_MSQ: begin
        ms_qd_nxt = ms_prod[MS_SHIFT +: MS_DIG_W];
        state_nxt = S_MSR;
      end
      S_MSR: begin
        ms_rem_nxt = ms_rem_full[MS_REM_W-1:0];
        ms_q_nxt   = {ms_q_r[MS_SRC_W-MS_DIG_W-1:0], ms_qd_r};
        ms_src_nxt = {ms_src_r[MS_SRC_W-MS_DIG_W-1:0], MS_DIG_W'(0)};
        ms_cnt_nxt = ms_cnt_r - MS_CNT_W'(1);
        state_nxt  = (ms_cnt_r == MS_CNT_W'(1)) ? S_MSCHK : S_MSQ;
      end
      S_MSCHK: begin
        if (!ms_big_r && ms_q_r == '0) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          iv_nxt    = (ms_big_r || ms_q_r[MS_SRC_W-1:IV_W] != '0) ? '1
                      : ms_q_r[IV_W-1:0];
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        win_we    = 1'b1;
        sum_nxt   = sum_r - (full_win ? SUM_W'(win_rd_r) : '0) + SUM_W'(iv_r);
        fill_nxt  = full_win ? fill_r : fill_r + FILL_W'(1);
        widx_nxt  = (widx_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : widx_r + IDX_W'(1);
        last_nxt  = iv_r;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        div_cmd.start      = 1'b1;
        div_cmd.short_mode = 1'b1;
        div_cmd.dividend   = TS_W'(BPM_Q8_NUM * 32'(fill_r));
        div_cmd.divisor    = sum_r;
        state_nxt          = S_BPM;
      end
      S_BPM: begin
        if (div_res.done) begin
          bpm_nxt   = div_res.quotient[BPM_W-1:0];
          out_load  = 1'b1;
          out_ivv   = 1'b1;
          out_iv    = iv_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_res.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      widx_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      last_r      <= '0;
      bpm_r       <= BPM_Q8_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      widx_r      <= widx_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      last_r      <= last_nxt;
      bpm_r       <= bpm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iv_r     <= iv_nxt;
    ms_src_r <= ms_src_nxt;
    ms_big_r <= ms_big_nxt;
    ms_rem_r <= ms_rem_nxt;
    ms_q_r   <= ms_q_nxt;
    ms_qd_r  <= ms_qd_nxt;
    ms_cnt_r <= ms_cnt_nxt;
    if (out_load) begin
      out_ivv_r  <= out_ivv;
      out_iv_r   <= out_iv;
      out_last_r <= last_r;
      out_bpm_r  <= bpm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[widx_r] <= iv_r;
    end
    win_rd_r <= win_mem[widx_r];
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.interval_valid   = out_ivv_r;
  assign out_res.interval_ms      = out_iv_r;
  assign out_res.last_interval_ms = out_last_r;
  assign out_res.bpm_q8           = out_bpm_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HISTORY_DEPTH))
    else $error("window fill beyond depth");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_r == '0) |-> (fill_r == '0))
    else $error("zero sum with nonempty window");

  a_empty_bpm: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (bpm_r == BPM_Q8_DEFAULT && last_r == '0))
    else $error("empty window reports a tempo");

  a_new_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ivv_r) |-> (out_last_r == out_iv_r && out_iv_r != '0))
    else $error("new interval is not the newest window entry");

endmodule

// ----- rtl/tap_tempo_tracker_unit.sv -----
// Top level of the tap tempo tracker.
//
//  channel | modport           | payload
//  in_req  | ttt_in_if.sink    | op, timestamp_us
//  out_res | ttt_out_if.source | interval_valid, interval_ms, last_interval_ms, bpm_q8
//
//  A forget, a first tap or a tap not later than the pending one: the result is registered
//  straight from idle once the request leaves the queue. A later tap runs a 3-digit
//  reciprocal millisecond conversion (S_MSQ then S_MSR per digit) and a check, which loads
//  the result when no interval results. A new interval adds the window update and a 32-bit tempo division.
//  The back part takes one request at a time and holds in idle while a result waits on
//  out_res.ready; a two-entry queue lets requests enter meanwhile. Reset is synchronous,
//  with no clearing pass; window entries hold no reset value.
module tap_tempo_tracker_unit
  import ttt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ttt_in_if.sink    in_req,
  ttt_out_if.source out_res
);

  logic         q_full, q_push, q_pop, q_empty;
  ttt_req_t     q_data, q_head;
  ttt_div_cmd_t div_cmd;
  ttt_div_res_t div_res;

  ttt_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  ttt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ttt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .res   (div_res)
  );

  ttt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .div_cmd (div_cmd),
    .div_res (div_res),
    .out_res (out_res)
  );

endmodule

// ----- test/tb_tap_tempo_tracker_unit.sv -----
// Testbench for tap_tempo_tracker_unit: directed and random tap requests checked by a tempo predictor.
`timescale 1ns / 100ps

module tb_tap_tempo_tracker_unit;
  import ttt_pkg::*;

  typedef struct packed {
    logic             interval_valid;
    logic [IV_W-1:0]  interval_ms;
    logic [IV_W-1:0]  last_interval_ms;
    logic [BPM_W-1:0] bpm_q8;
  } tempo_report_t;

  typedef struct packed {
    ttt_op_t         op;
    logic [TS_W-1:0] ts;
    logic            typed;
    tempo_report_t   want;
  } script_row_t;

  localparam int RANDOM_REQS = 1800;
  localparam int SCRIPT_LEN  = 23;

  localparam tempo_report_t EMPTY_REPORT = '{1'b0, 32'd0, 32'd0, BPM_Q8_DEFAULT};
  localparam tempo_report_t FASTEST      = '{1'b0, 32'd0, 32'd1, 24'd15360000};
  localparam tempo_report_t SATURATED    = '{1'b0, 32'd0, 32'hFFFF_FFFF, 24'd0};

  localparam script_row_t TAP_SCRIPT [SCRIPT_LEN] = '{
    '{OP_FORGET, 64'd0,                   1'b1, EMPTY_REPORT},
    '{OP_TAP,    64'd0,                   1'b1, EMPTY_REPORT},
    '{OP_TAP,    64'd1000,                1'b1, EMPTY_REPORT},
    '{OP_TAP,    64'd1999,                1'b1, EMPTY_REPORT},
    '{OP_TAP,    64'd2999,                1'b1, '{1'b1, 32'd1, 32'd1, 24'd15360000}},
    '{OP_TAP,    64'd2999,                1'b1, FASTEST},
    '{OP_TAP,    64'd1,                   1'b1, FASTEST},
    '{OP_TAP,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd0}},
    '{OP_FORGET, 64'd0,                   1'b1, SATURATED},
    '{OP_TAP,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, SATURATED},
    '{OP_TAP,    64'd0,                   1'b1, SATURATED},
    '{OP_TAP,    64'd500000,              1'b1, SATURATED},
    '{OP_TAP,    64'd1000000,             1'b0, '0},
    '{OP_TAP,    64'd1500000,             1'b0, '0},
    '{OP_TAP,    64'd2000000,             1'b0, '0},
    '{OP_TAP,    64'd2500000,             1'b0, '0},
    '{OP_TAP,    64'd3000000,             1'b0, '0},
    '{OP_TAP,    64'd3500000,             1'b0, '0},
    '{OP_TAP,    64'd4000000,             1'b0, '0},
    '{OP_TAP,    64'd4500000,             1'b0, '0},
    '{OP_TAP,    64'd4294971795999,       1'b0, '0},
    '{OP_TAP,    64'd4294971796999,       1'b0, '0},
    '{OP_FORGET, 64'hA5A5_5A5A_F0F0_0F0F, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  ttt_in_if  in_req ();
  ttt_out_if out_res ();

  tap_tempo_tracker_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  tempo_report_t   pending_reports [$];
  logic [TS_W-1:0] held_tap_us = '0;
  logic [IV_W-1:0] iv_ring [HISTORY_DEPTH];
  int unsigned     ring_head = 0;
  int unsigned     ring_fill = 0;
  longint unsigned ring_sum  = 0;
  logic [TS_W-1:0] tap_clock = 64'd10_000_000;

  int errors       = 0;
  int reqs_sent    = 0;
  int forgets      = 0;
  int intervals    = 0;
  int saturations  = 0;
  int overwrites   = 0;
  int reports_seen = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_400_000;
    $display("FAIL");
    $finish;
  end

  function automatic tempo_report_t track_tempo(ttt_op_t op, logic [TS_W-1:0] ts);
    tempo_report_t   r;
    logic [TS_W-1:0] gap_ms;
    r = '0;
    if (op == OP_FORGET) begin
      held_tap_us = '0;
      forgets++;
    end else begin
      if (held_tap_us != '0 && ts > held_tap_us) begin
        gap_ms = (ts - held_tap_us) / TS_W'(US_PER_MS);
        if (gap_ms != '0) begin
          r.interval_valid = 1'b1;
          r.interval_ms    = (gap_ms > 64'hFFFF_FFFF) ? '1 : gap_ms[IV_W-1:0];
          if (gap_ms > 64'hFFFF_FFFF) saturations++;
          if (ring_fill == HISTORY_DEPTH) begin
            ring_sum -= iv_ring[ring_head];
            overwrites++;
          end else begin
            ring_fill++;
          end
          iv_ring[ring_head] = r.interval_ms;
          ring_sum += r.interval_ms;
          ring_head = (ring_head + 1) % HISTORY_DEPTH;
          intervals++;
        end
      end
      held_tap_us = ts;
    end
    if (ring_fill != 0) begin
      r.last_interval_ms = iv_ring[(ring_head + HISTORY_DEPTH - 1) % HISTORY_DEPTH];
      r.bpm_q8 = BPM_W'((64'(BPM_Q8_NUM) * ring_fill) / ring_sum);
    end else begin
      r.bpm_q8 = BPM_Q8_DEFAULT;
    end
    return r;
  endfunction

  task automatic put_req(input ttt_op_t op, input logic [TS_W-1:0] ts,
                         input logic typed, input tempo_report_t want);
    tempo_report_t predicted;
    in_req.valid        = 1'b1;
    in_req.op           = op;
    in_req.timestamp_us = ts;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    predicted = track_tempo(op, ts);
    pending_reports = {pending_reports, (typed ? want : predicted)};
    reqs_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles != 0) begin
      in_req.valid = 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic pick_random_req(output ttt_op_t op, output logic [TS_W-1:0] ts);
    int choice;
    choice = $urandom_range(0, 99);
    op = OP_TAP;
    if (choice < 3) begin
      op = OP_FORGET;
      ts = {$urandom, $urandom};
      return;
    end else if (choice < 5) begin
      tap_clock = '0;
    end else if (choice < 8) begin
      tap_clock = {$urandom, $urandom};
    end else if (choice < 12) begin
      tap_clock += {$urandom, $urandom};
    end else if (choice < 20) begin
      if (choice >= 16) tap_clock -= $urandom_range(1, 5_000_000);
    end else if (choice < 26) begin
      tap_clock += $urandom_range(0, 999);
    end else if (choice < 32) begin
      tap_clock += $urandom_range(1, 4) * 1000 + ($urandom_range(0, 1) ? 999 : 0);
    end else begin
      tap_clock += $urandom_range(150_000, 2_000_000);
    end
    ts = tap_clock;
  endtask

  initial begin
    int mode;
    out_res.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        out_res.ready = 1'b1;
        repeat ($urandom_range(50, 300)) @(negedge clk);
      end else begin
        out_res.ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_res.ready = 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    tempo_report_t want;
    if (rst_n && out_res.valid === 1'b1 && out_res.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: interval_ms %0d, bpm_q8 %0d",
               out_res.interval_ms, out_res.bpm_q8);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        reports_seen++;
        if (out_res.interval_valid !== want.interval_valid) begin
          $error("interval_valid: expected %0d, got %0d",
                 want.interval_valid, out_res.interval_valid);
          errors++;
        end
        if (out_res.interval_ms !== want.interval_ms) begin
          $error("interval_ms: expected %0d, got %0d", want.interval_ms, out_res.interval_ms);
          errors++;
        end
        if (out_res.last_interval_ms !== want.last_interval_ms) begin
          $error("last_interval_ms: expected %0d, got %0d",
                 want.last_interval_ms, out_res.last_interval_ms);
          errors++;
        end
        if (out_res.bpm_q8 !== want.bpm_q8) begin
          $error("bpm_q8: expected %0d, got %0d", want.bpm_q8, out_res.bpm_q8);
          errors++;
        end
      end
    end
  end

  initial begin
    ttt_op_t         op;
    logic [TS_W-1:0] ts;
    int              burst;
    int              sent;
    int              next_drain;
    in_req.valid        = 1'b0;
    in_req.op           = OP_TAP;
    in_req.timestamp_us = '0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (TAP_SCRIPT[i]) begin
      put_req(TAP_SCRIPT[i].op, TAP_SCRIPT[i].ts, TAP_SCRIPT[i].typed, TAP_SCRIPT[i].want);
      idle_sender($urandom_range(0, 2));
    end

    sent       = 0;
    next_drain = 450;
    while (sent < RANDOM_REQS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        pick_random_req(op, ts);
        put_req(op, ts, 1'b0, '0);
        sent++;
      end
      idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      if (sent >= next_drain) begin
        // hold off until every pending request has reported
        in_req.valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
        next_drain += 450;
      end
    end

    in_req.valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);

    $display("Sent %0d requests (%0d forgets), checked %0d results.", reqs_sent, forgets,
             reports_seen);
    $display("Intervals: %0d pushed, %0d saturated, %0d replaced an older entry.", intervals,
             saturations, overwrites);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ttt_pkg.sv
rtl/ttt_if.sv
rtl/ttt_queue.sv
rtl/ttt_front.sv
rtl/ttt_div.sv
rtl/ttt_back.sv
rtl/tap_tempo_tracker_unit.sv
test/tb_tap_tempo_tracker_unit.sv
